>>> design/lrupr_pkg.sv
package lrupr_pkg;

    localparam int CFG_BITS   = 3;
    localparam int FAULT_BITS = 32;
    localparam int FIDX_BITS  = 2;
    localparam int ACT_BITS   = 8;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_done;
    } t_ctrl_sts;

endpackage

>>> design/lrupr_ctrl.sv
module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/lrupr_dpath.sv
module lrupr_dpath
    import lrupr_pkg::*;
#(
    parameter int FRAMES     = 4,
    parameter int PAGE_BITS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_sts             o_sts,
    input  logic [PAGE_BITS-1:0]  i_page_number,
    input  logic                  i_cfg_valid,
    input  logic [CFG_BITS-1:0]   i_cfg_data,
    output logic                  o_result_valid,
    output logic                  o_was_hit,
    output logic [FIDX_BITS-1:0]  o_frame_index,
    output logic                  o_evicted_valid,
    output logic [PAGE_BITS-1:0]  o_evicted_page,
    output logic [FAULT_BITS-1:0] o_fault_total,
    output logic                  o_stamp_overflow
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    logic [CFG_BITS-1:0]   r_cfg;
    logic [FRAMES-1:0]     r_frame_valid;
    logic [PAGE_BITS-1:0]  page_mem [FRAMES];
    logic [STAMP_BITS-1:0] stamp_mem [FRAMES];

    logic [PAGE_BITS-1:0]  r_page;
    logic [CNT_W-1:0]      r_rd_idx;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic [PAGE_BITS-1:0]  r_rd_page;
    logic [STAMP_BITS-1:0] r_rd_stamp;

    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic                  r_empty;
    logic [IDX_W-1:0]      r_empty_idx;
    logic                  r_min_set;
    logic [IDX_W-1:0]      r_min_idx;
    logic [STAMP_BITS-1:0] r_min_stamp;
    logic [PAGE_BITS-1:0]  r_min_page;

    logic [STAMP_BITS-1:0] r_use_counter;
    logic [FAULT_BITS-1:0] r_fault_count;
    logic                  r_overflow;
    logic                  r_result_valid_q;

    logic [ACT_BITS-1:0]   cfg_ext;
    logic [ACT_BITS-1:0]   act;
    logic [IDX_W-1:0]      last_idx;
    logic                  rd_en;
    logic                  cmp_valid_bit;
    logic [IDX_W-1:0]      pos;
    logic [IDX_W+1:0]      pos_ext;
    logic                  evict;
    logic [STAMP_BITS-1:0] n_stamp;
    logic                  n_overflow;
    logic [FAULT_BITS-1:0] n_fault;

    // active frame count, clamped to 1..FRAMES
    always_comb begin
        cfg_ext = ACT_BITS'(r_cfg);
        if (r_cfg == '0) begin
            act = ACT_BITS'(1);
        end else if (cfg_ext > ACT_BITS'(FRAMES)) begin
            act = ACT_BITS'(FRAMES);
        end else begin
            act = cfg_ext;
        end
        last_idx = IDX_W'(act - ACT_BITS'(1));
    end

    assign rd_en         = i_cmd.scan && (r_rd_idx <= CNT_W'(last_idx));
    assign cmp_valid_bit = r_frame_valid[r_cmp_idx];
    assign o_sts.scan_done = r_cmp_vld && (r_cmp_idx == last_idx);

    always_comb begin
        evict = 1'b0;
        if (r_hit) begin
            pos = r_hit_idx;
        end else if (r_empty) begin
            pos = r_empty_idx;
        end else begin
            pos   = r_min_idx;
            evict = 1'b1;
        end
        pos_ext = {2'b00, pos};

        n_overflow = r_overflow;
        if (r_use_counter == '1) begin
            n_stamp    = r_use_counter;
            n_overflow = 1'b1;
        end else begin
            n_stamp = r_use_counter + STAMP_BITS'(1);
            if (n_stamp == '1) begin
                n_overflow = 1'b1;
            end
        end

        n_fault = r_fault_count;
        if (!r_hit && (r_fault_count != '1)) begin
            n_fault = r_fault_count + FAULT_BITS'(1);
        end
    end

    // frame memories
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_page  <= page_mem[r_rd_idx[IDX_W-1:0]];
            r_rd_stamp <= stamp_mem[r_rd_idx[IDX_W-1:0]];
        end
        if (i_cmd.commit) begin
            stamp_mem[pos] <= n_stamp;
            if (!r_hit) begin
                page_mem[pos] <= r_page;
            end
        end
    end

    // scan pipeline and search flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_empty   <= 1'b0;
            r_min_set <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_empty   <= 1'b0;
            r_min_set <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (r_cmp_vld) begin
                if (cmp_valid_bit && (r_rd_page == r_page) && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!cmp_valid_bit && !r_empty) begin
                    r_empty <= 1'b1;
                end
                if (cmp_valid_bit && (!r_min_set || (r_rd_stamp < r_min_stamp))) begin
                    r_min_set <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_page_number;
        end
        if (rd_en) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (r_cmp_vld && !i_cmd.load) begin
            if (cmp_valid_bit && (r_rd_page == r_page) && !r_hit) begin
                r_hit_idx <= r_cmp_idx;
            end
            if (!cmp_valid_bit && !r_empty) begin
                r_empty_idx <= r_cmp_idx;
            end
            if (cmp_valid_bit && (!r_min_set || (r_rd_stamp < r_min_stamp))) begin
                r_min_idx   <= r_cmp_idx;
                r_min_stamp <= r_rd_stamp;
                r_min_page  <= r_rd_page;
            end
        end
    end

    // config, frame valid bits, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg          <= CFG_RESET;
            r_frame_valid  <= '0;
            r_use_counter  <= '0;
            r_fault_count  <= '0;
            r_overflow     <= 1'b0;
            r_result_valid_q <= 1'b0;
        end else begin
            r_result_valid_q <= i_cmd.commit;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_frame_valid[pos] <= 1'b1;
                r_use_counter      <= n_stamp;
                r_fault_count      <= n_fault;
                r_overflow         <= n_overflow;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_was_hit        <= r_hit;
            o_frame_index    <= pos_ext[FIDX_BITS-1:0];
            o_evicted_valid  <= evict;
            o_evicted_page   <= evict ? r_min_page : '0;
            o_fault_total    <= n_fault;
            o_stamp_overflow <= n_overflow;
        end
    end

    assign o_result_valid = r_result_valid_q;

endmodule

>>> design/lru_page_replacement_core.sv
// one page reference per transaction, one result per transaction
// throughput: one reference at a time, start is taken only while busy is low;
// the scan reads one frame per cycle over the active frames, which is the
// configured frame count (i_cfg_data) clamped to 1..FRAMES
// synchronous active-low reset empties all frames, clears counters, sets 4 frames
// the result strobe lasts one cycle; the receiver cannot stall
module lru_page_replacement_core
    import lrupr_pkg::*;
#(
    parameter int FRAMES     = 4,
    parameter int PAGE_BITS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PAGE_BITS-1:0]  i_page_number,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_BITS-1:0]   i_cfg_data,
    output logic                  o_result_valid,
    output logic                  o_was_hit,
    output logic [FIDX_BITS-1:0]  o_frame_index,
    output logic                  o_evicted_valid,
    output logic [PAGE_BITS-1:0]  o_evicted_page,
    output logic [FAULT_BITS-1:0] o_fault_total,
    output logic                  o_stamp_overflow
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    assign o_cfg_ready = 1'b1;

    lrupr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lrupr_dpath #(
        .FRAMES     (FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_page_number    (i_page_number),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_was_hit        (o_was_hit),
        .o_frame_index    (o_frame_index),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_page   (o_evicted_page),
        .o_fault_total    (o_fault_total),
        .o_stamp_overflow (o_stamp_overflow)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import lrupr_pkg::*;

    localparam int FRAMES          = 4;
    localparam int PAGE_BITS       = 16;
    localparam int STAMP_BITS      = 32;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 143;
    localparam int MAX_POOL        = 8;

    typedef struct packed {
        logic                  was_hit;
        logic [FIDX_BITS-1:0]  frame_index;
        logic                  evicted_valid;
        logic [PAGE_BITS-1:0]  evicted_page;
        logic [FAULT_BITS-1:0] fault_total;
        logic                  stamp_overflow;
    } lookup_result_t;

    typedef enum logic {
        ROW_REF,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [PAGE_BITS-1:0]  value;
        bit                    typed;
        lookup_result_t        want;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [PAGE_BITS-1:0]  i_page_number;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_BITS-1:0]   i_cfg_data;
    logic                  o_result_valid;
    logic                  o_was_hit;
    logic [FIDX_BITS-1:0]  o_frame_index;
    logic                  o_evicted_valid;
    logic [PAGE_BITS-1:0]  o_evicted_page;
    logic [FAULT_BITS-1:0] o_fault_total;
    logic                  o_stamp_overflow;

    // predictor state
    bit                    frame_used [FRAMES];
    logic [PAGE_BITS-1:0]  frame_page [FRAMES];
    logic [STAMP_BITS-1:0] frame_stamp [FRAMES];
    logic [STAMP_BITS-1:0] use_count = '0;
    logic [FAULT_BITS-1:0] fault_count = '0;
    bit                    overflow_flag = 1'b0;
    logic [CFG_BITS-1:0]   frames_cfg = CFG_RESET;

    lookup_result_t        pending_lookups [$];
    stim_row_t             directed_rows [$];
    lookup_result_t        typed_want;
    bit                    typed_row = 1'b0;
    bit                    burst_mode = 1'b0;
    int                    errors = 0;
    int                    idle_cycles = 0;
    logic [PAGE_BITS-1:0]  page_pool [MAX_POOL];

    lru_page_replacement_core #(
        .FRAMES     (FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_page_number    (i_page_number),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_was_hit        (o_was_hit),
        .o_frame_index    (o_frame_index),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_page   (o_evicted_page),
        .o_fault_total    (o_fault_total),
        .o_stamp_overflow (o_stamp_overflow)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic lookup_result_t predict_lookup(input logic [PAGE_BITS-1:0] page);
        lookup_result_t res;
        int active;
        int pos;
        bit hit;
        bit found;
        logic [STAMP_BITS-1:0] best;
        res    = '0;
        active = int'(frames_cfg);
        pos    = 0;
        hit    = 1'b0;
        found  = 1'b0;
        if (active < 1) active = 1;
        if (active > FRAMES) active = FRAMES;
        for (int i = 0; i < active && !found; i++) begin
            if (frame_used[i] && frame_page[i] == page) begin
                pos   = i;
                hit   = 1'b1;
                found = 1'b1;
            end
        end
        for (int i = 0; i < active && !found; i++) begin
            if (!frame_used[i]) begin
                pos   = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            best = frame_stamp[0];
            pos  = 0;
            for (int i = 1; i < active; i++) begin
                if (frame_stamp[i] < best) begin
                    best = frame_stamp[i];
                    pos  = i;
                end
            end
            res.evicted_valid = 1'b1;
            res.evicted_page  = frame_page[pos];
        end
        // saturating use stamp
        if (use_count == '1) begin
            overflow_flag = 1'b1;
        end else begin
            use_count = use_count + 1'b1;
            if (use_count == '1) overflow_flag = 1'b1;
        end
        frame_stamp[pos] = use_count;
        if (!hit) begin
            frame_used[pos] = 1'b1;
            frame_page[pos] = page;
            if (fault_count != '1) fault_count = fault_count + 1'b1;
        end
        res.was_hit        = hit;
        res.frame_index    = pos[FIDX_BITS-1:0];
        res.fault_total    = fault_count;
        res.stamp_overflow = overflow_flag;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode) return 0;
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // monitor: config transactions, result checks, accepted references
    always @(posedge i_clk) begin
        lookup_result_t want;
        lookup_result_t pred;
        bit activity;
        activity = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                frames_cfg = i_cfg_data;
                activity   = 1'b1;
            end
            if (o_result_valid) begin
                activity = 1'b1;
                if (pending_lookups.size() == 0) begin
                    $display("%0t unexpected result: expected none actual frame %0d", $time,
                             o_frame_index);
                    errors++;
                end else begin
                    want = pending_lookups.pop_front();
                    check_field("was_hit", want.was_hit, o_was_hit);
                    check_field("frame_index", want.frame_index, o_frame_index);
                    check_field("evicted_valid", want.evicted_valid, o_evicted_valid);
                    check_field("evicted_page", want.evicted_page, o_evicted_page);
                    check_field("fault_total", want.fault_total, o_fault_total);
                    check_field("stamp_overflow", want.stamp_overflow, o_stamp_overflow);
                end
            end
            if (start && !busy) begin
                activity = 1'b1;
                pred = predict_lookup(i_page_number);
                pending_lookups.push_back(typed_row ? typed_want : pred);
            end
        end
        idle_cycles <= activity ? 0 : idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // called just after a falling edge, returns just after a falling edge
    task automatic issue_reference(input logic [PAGE_BITS-1:0] page, input int gap,
                                   input bit typed, input lookup_result_t want);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         = 1'b1;
        i_page_number = page;
        typed_row     = typed;
        typed_want    = want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_lookups();
        start = 1'b0;
        do @(negedge i_clk); while (pending_lookups.size() != 0);
    endtask

    task automatic write_frames(input logic [CFG_BITS-1:0] value);
        drain_lookups();
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [PAGE_BITS-1:0] value);
        stim_row_t row;
        row.kind  = kind;
        row.value = value;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [PAGE_BITS-1:0] page, input logic hit,
                             input logic [FIDX_BITS-1:0] idx, input logic ev,
                             input logic [PAGE_BITS-1:0] ev_page,
                             input logic [FAULT_BITS-1:0] faults);
        stim_row_t row;
        row.kind  = ROW_REF;
        row.value = page;
        row.typed = 1'b1;
        row.want  = '{hit, idx, ev, ev_page, faults, 1'b0};
        directed_rows.push_back(row);
    endtask

    initial begin
        logic [CFG_BITS-1:0] phase_cfg [RANDOM_PHASES];
        logic [PAGE_BITS-1:0] page;
        int pool_size;
        int r;
        for (int i = 0; i < FRAMES; i++) begin
            frame_used[i]  = 1'b0;
            frame_page[i]  = '0;
            frame_stamp[i] = '0;
        end
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_page_number = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        typed_want    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill from empty, then lru eviction with extreme pages
        add_typed(16'h0000, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd1);
        add_typed(16'hFFFF, 1'b0, 2'd1, 1'b0, 16'h0000, 32'd2);
        add_typed(16'h0000, 1'b1, 2'd0, 1'b0, 16'h0000, 32'd2);
        add_row(ROW_REF, 16'h8001);
        add_row(ROW_REF, 16'h7FFE);
        add_typed(16'h1234, 1'b0, 2'd1, 1'b1, 16'hFFFF, 32'd5);
        add_typed(16'hFFFF, 1'b0, 2'd0, 1'b1, 16'h0000, 32'd6);
        add_row(ROW_REF, 16'h1234);
        // single frame, zero acts as one
        add_row(ROW_CFG, 16'd1);
        add_row(ROW_REF, 16'h1234);
        add_row(ROW_REF, 16'h5555);
        add_row(ROW_CFG, 16'd0);
        add_row(ROW_REF, 16'h5555);
        add_row(ROW_REF, 16'hAAAA);
        // shrink then grow past the frame count, old contents come back
        add_row(ROW_CFG, 16'd2);
        add_row(ROW_REF, 16'h1234);
        add_row(ROW_REF, 16'h0F0F);
        add_row(ROW_CFG, 16'd7);
        add_row(ROW_REF, 16'h8001);
        add_row(ROW_REF, 16'h7FFE);
        add_row(ROW_REF, 16'h3C3C);
        add_row(ROW_CFG, 16'd3);
        add_row(ROW_REF, 16'h8001);
        add_row(ROW_REF, 16'h0001);
        add_row(ROW_REF, 16'hFFFE);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_frames(directed_rows[i].value[CFG_BITS-1:0]);
            end else begin
                issue_reference(directed_rows[i].value, pick_gap(), directed_rows[i].typed,
                                directed_rows[i].want);
            end
        end

        phase_cfg = '{3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6, 3'd4};
        phase_cfg[RANDOM_PHASES-1] = CFG_BITS'($urandom_range(0, 7));
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_frames(phase_cfg[p]);
            pool_size = $urandom_range(2, MAX_POOL);
            for (int k = 0; k < MAX_POOL; k++) page_pool[k] = PAGE_BITS'($urandom);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
                if (p == 2 && n == ITEMS_PER_PHASE / 2) drain_lookups();
                r = $urandom_range(0, 99);
                if (r < 80) page = page_pool[$urandom_range(0, pool_size - 1)];
                else page = PAGE_BITS'($urandom);
                issue_reference(page, pick_gap(), 1'b0, '0);
            end
        end
        burst_mode = 1'b0;

        drain_lookups();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/lrupr_pkg.sv
design/lrupr_ctrl.sv
design/lrupr_dpath.sv
design/lru_page_replacement_core.sv
dv/tb.sv
